// ----- src/pbwt_pkg.sv -----
// Shared types and constants of the PBWT column update block.
// No dependencies; imported by pbwt_column_update_unit.
package pbwt_pkg;

    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 32;
    localparam int CFG_W      = 7;
    localparam int HAP_W      = 6;
    localparam int LEN_OUT_W  = 16;
    localparam int RESULT_LIMIT = 64;

    typedef enum logic [5:0] {
        ST_LOAD  = 6'b000001,
        ST_PASSA = 6'b000010,
        ST_PASSB = 6'b000100,
        ST_ERD   = 6'b001000,
        ST_EDATA = 6'b010000,
        ST_EHOLD = 6'b100000
    } t_state;

endpackage

// ----- src/pbwt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pbwt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- src/pbwt_column_update_unit.sv -----
// Top level of the PBWT column update block.
// Depends on pbwt_pkg and pbwt_ram.
//
// Usage: the cfg channel writes the haplotype count h (clamped to 2..64 and to
// MAX_HAPLOTYPES) and restarts the panel: prefix order identity, match lengths
// zero, any partial column dropped. The slave stream takes one allele bit per
// request (tdata bit 0), one per cycle, in haplotype order. After the h-th bit
// the block runs two passes over the stored prefix order: the first reads the
// column bits through the prefix order and finds runs and thresholds, the
// second partitions the order and writes the new prefix and match-length
// arrays into the spare bank. It then emits h results on the master stream,
// tlast on the final one, and swaps banks.
// The passes are paced by the one-read-port RAMs. Each result steps through the
// read, data and hold states, and the next is not read until the receiver takes
// the current one. A stalled receiver holds the current result; no input is
// taken until the column is fully delivered. Reset gives identity order, zero
// lengths and h = min(MAX_HAPLOTYPES, 64).
module pbwt_column_update_unit #(
    parameter int MAX_HAPLOTYPES = 64,
    parameter int LENGTH_BITS    = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [pbwt_pkg::CFG_W-1:0]           i_cfg_data,       // haplotype_count
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    input  logic [pbwt_pkg::IN_DATA_W-1:0]       i_s_axis_tdata,   // [0] allele
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // [5:0] sorted_haplotype, [6] sorted_allele, [7] run_end, [8] threshold_mark,
    // [14:9] next_haplotype, [30:15] next_match_length, [31] zero
    output logic [pbwt_pkg::OUT_DATA_W-1:0]      o_m_axis_tdata,
    output logic                                 o_m_axis_tlast
);
    import pbwt_pkg::*;

    localparam int HLIM = (MAX_HAPLOTYPES < RESULT_LIMIT) ? MAX_HAPLOTYPES : RESULT_LIMIT;
    localparam int AW   = (HLIM > 1) ? $clog2(HLIM) : 1;
    localparam int CW   = $clog2(HLIM + 1);
    localparam logic [LENGTH_BITS-1:0] LMAX = '1;

    t_state r_state, n_state;
    logic [CW-1:0] r_h, r_idx, r_zeros, r_nz, r_no;
    logic r_bank, r_fresh;
    logic r_a1_v, r_a2_v, r_b1_v;
    logic [AW-1:0] r_a1_idx, r_a2_idx, r_b1_idx, r_thr;
    logic [LENGTH_BITS-1:0] r_a2_d, r_min, r_acc0, r_acc1;
    logic r_open0, r_open1, r_prev_al;
    logic r_mfin;
    logic r_o_valid, r_o_last;
    logic [OUT_DATA_W-1:0] r_o_data;

    logic [HAP_W-1:0] p0_rd, p1_rd;
    logic [LENGTH_BITS-1:0] d0_rd, d1_rd;
    logic [AW-1:0] p0_rd_a, p1_rd_a, p_cur, p_nxt, col_raddr, hap_cur;
    logic [LENGTH_BITS-1:0] d_cur, d_nxt;
    logic col_rd, col_we;
    logic al_rd, aln_rd, al_we;
    logic mk_rd, mk_we, mk_wdata;
    logic [AW-1:0] mk_waddr;
    logic we, we0, we1;
    logic [AW-1:0] waddr;
    logic [AW-1:0] wdata_p;
    logic [LENGTH_BITS-1:0] wdata_d;
    logic [AW-1:0] ridx;

    logic s_acc, m_acc;
    logic a_new, a_al;
    logic [AW-1:0] a_thr;
    logic [LENGTH_BITS-1:0] a_min;
    logic b_al;
    logic [LENGTH_BITS-1:0] b_d, acc0n, acc1n, b_acc, b_len;
    logic [CW-1:0] b_dest;
    logic b_zero;
    logic [AW-1:0] e_i, e_nx;
    logic e_last, e_runend;
    logic [31:0] e_len;
    logic [CW-1:0] cfg_h;

    assign ridx = r_idx[AW-1:0];
    assign p0_rd_a = AW'(p0_rd);
    assign p1_rd_a = AW'(p1_rd);
    assign p_cur = r_bank ? p1_rd_a : p0_rd_a;
    assign p_nxt = r_bank ? p0_rd_a : p1_rd_a;
    assign d_cur = r_bank ? d1_rd : d0_rd;
    assign d_nxt = r_bank ? d0_rd : d1_rd;

    assign s_acc = i_s_axis_tvalid && o_s_axis_tready;
    assign m_acc = r_o_valid && i_m_axis_tready;
    assign o_s_axis_tready = (r_state == ST_LOAD);
    assign o_cfg_ready = 1'b1;
    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata = r_o_data;
    assign o_m_axis_tlast = r_o_last;

    assign col_we = s_acc;
    assign col_raddr = r_fresh ? r_a1_idx : p_cur;

    assign al_we = (r_state == ST_PASSA) && r_a2_v;

    // clear marks while loading, set a mark at each run's threshold when the run ends
    assign mk_we    = (r_state == ST_LOAD)
                   || (al_we && a_new && (r_a2_idx != '0))
                   || r_mfin;
    assign mk_waddr = (r_state == ST_LOAD) ? ridx : r_thr;
    assign mk_wdata = (r_state != ST_LOAD);

    always_comb begin
        if (32'(i_cfg_data) < 2) begin
            cfg_h = CW'(2);
        end else if (32'(i_cfg_data) > HLIM) begin
            cfg_h = CW'(HLIM);
        end else begin
            cfg_h = CW'(i_cfg_data);
        end
    end

    // pass A: run and threshold tracking
    always_comb begin
        a_al  = col_rd;
        a_new = (r_a2_idx == '0) || (a_al != r_prev_al);
        if (a_new || r_a2_d < r_min) begin
            a_thr = r_a2_idx;
            a_min = r_a2_d;
        end else begin
            a_thr = r_thr;
            a_min = r_min;
        end
    end

    // pass B: stable partition and new lengths
    always_comb begin
        b_al  = al_rd;
        b_d   = r_fresh ? '0 : d_cur;
        hap_cur = r_fresh ? r_b1_idx : p_cur;
        acc0n = (!r_open0 || b_d < r_acc0) ? b_d : r_acc0;
        acc1n = (!r_open1 || b_d < r_acc1) ? b_d : r_acc1;
        b_acc = b_al ? acc1n : acc0n;
        b_dest = b_al ? CW'(r_zeros + r_no) : r_nz;
        b_zero = b_al ? (r_no == '0) : (r_nz == '0);
        if (b_zero) begin
            b_len = '0;
        end else if (b_acc == LMAX) begin
            b_len = LMAX;
        end else begin
            b_len = b_acc + 1'b1;
        end
        we      = (r_state == ST_PASSB) && r_b1_v;
        waddr   = b_dest[AW-1:0];
        wdata_p = hap_cur;
        wdata_d = b_len;
        we0     = we && r_bank;
        we1     = we && !r_bank;
    end

    always_comb begin
        e_i      = ridx;
        e_nx     = e_i + 1'b1;
        e_last   = (r_idx == r_h - 1'b1);
        e_runend = e_last || (al_rd != aln_rd);
        e_len    = 32'(d_nxt);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD:  if (s_acc && (r_idx + 1'b1 == r_h)) n_state = ST_PASSA;
            ST_PASSA: if (r_a2_v && (CW'(r_a2_idx) == r_h - 1'b1)) n_state = ST_PASSB;
            ST_PASSB: if (r_b1_v && (CW'(r_b1_idx) == r_h - 1'b1)) n_state = ST_ERD;
            ST_ERD:   n_state = ST_EDATA;
            ST_EDATA: n_state = ST_EHOLD;
            ST_EHOLD: begin
                if (m_acc) begin
                    n_state = r_o_last ? ST_LOAD : ST_ERD;
                end
            end
            default:  n_state = ST_LOAD;
        endcase
        if (i_cfg_valid) begin
            n_state = ST_LOAD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_LOAD;
            r_h       <= CW'(HLIM);
            r_idx     <= '0;
            r_bank    <= 1'b0;
            r_fresh   <= 1'b1;
            r_a1_v    <= 1'b0;
            r_a2_v    <= 1'b0;
            r_b1_v    <= 1'b0;
            r_mfin    <= 1'b0;
            r_o_valid <= 1'b0;
            r_o_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_mfin  <= (r_state == ST_PASSA) && (n_state == ST_PASSB);
            if (i_cfg_valid) begin
                r_h       <= cfg_h;
                r_idx     <= '0;
                r_fresh   <= 1'b1;
                r_a1_v    <= 1'b0;
                r_a2_v    <= 1'b0;
                r_b1_v    <= 1'b0;
                r_o_valid <= 1'b0;
            end else begin
                unique case (r_state)
                    ST_LOAD: begin
                        if (s_acc) begin
                            r_idx <= (n_state == ST_PASSA) ? '0 : r_idx + 1'b1;
                        end
                    end
                    ST_PASSA: begin
                        if (n_state == ST_PASSB) begin
                            r_idx  <= '0;
                            r_a1_v <= 1'b0;
                            r_a2_v <= 1'b0;
                        end else begin
                            r_a1_v <= (r_idx < r_h);
                            if (r_idx < r_h) r_idx <= r_idx + 1'b1;
                            r_a2_v <= r_a1_v;
                        end
                    end
                    ST_PASSB: begin
                        if (n_state == ST_ERD) begin
                            r_idx  <= '0;
                            r_b1_v <= 1'b0;
                        end else begin
                            r_b1_v <= (r_idx < r_h);
                            if (r_idx < r_h) r_idx <= r_idx + 1'b1;
                        end
                    end
                    ST_ERD: begin
                    end
                    ST_EDATA: begin
                        r_o_valid <= 1'b1;
                        r_o_last  <= e_last;
                    end
                    ST_EHOLD: begin
                        if (m_acc) begin
                            r_o_valid <= 1'b0;
                            r_idx     <= r_o_last ? '0 : r_idx + 1'b1;
                            if (r_o_last) begin
                                r_bank  <= !r_bank;
                                r_fresh <= 1'b0;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_a1_idx <= ridx;
        r_a2_idx <= r_a1_idx;
        r_a2_d   <= r_fresh ? '0 : d_cur;
        r_b1_idx <= ridx;
        if (r_state == ST_LOAD) begin
            r_zeros <= '0;
            r_nz    <= '0;
            r_no    <= '0;
            r_open0 <= 1'b0;
            r_open1 <= 1'b0;
        end
        if (al_we) begin
            r_prev_al <= a_al;
            r_thr     <= a_thr;
            r_min     <= a_min;
            if (!a_al) r_zeros <= r_zeros + 1'b1;
        end
        if (we) begin
            r_acc0  <= acc0n;
            r_acc1  <= acc1n;
            r_open0 <= b_al;
            r_open1 <= !b_al;
            if (b_al) r_no <= r_no + 1'b1;
            else      r_nz <= r_nz + 1'b1;
        end
        if (r_state == ST_EDATA) begin
            r_o_data <= {1'b0, e_len[LEN_OUT_W-1:0], HAP_W'(p_nxt), mk_rd, e_runend,
                         al_rd, HAP_W'(r_fresh ? e_i : p_cur)};
        end
    end

    pbwt_ram #(.WIDTH(1), .DEPTH(HLIM)) u_col (
        .i_clk(i_clk), .i_we(col_we), .i_waddr(ridx), .i_wdata(i_s_axis_tdata[0]),
        .i_raddr(col_raddr), .o_rdata(col_rd)
    );
    pbwt_ram #(.WIDTH(1), .DEPTH(HLIM)) u_al (
        .i_clk(i_clk), .i_we(al_we), .i_waddr(r_a2_idx), .i_wdata(a_al),
        .i_raddr(ridx), .o_rdata(al_rd)
    );
    pbwt_ram #(.WIDTH(1), .DEPTH(HLIM)) u_aln (
        .i_clk(i_clk), .i_we(al_we), .i_waddr(r_a2_idx), .i_wdata(a_al),
        .i_raddr(e_nx), .o_rdata(aln_rd)
    );
    pbwt_ram #(.WIDTH(1), .DEPTH(HLIM)) u_mark (
        .i_clk(i_clk), .i_we(mk_we), .i_waddr(mk_waddr), .i_wdata(mk_wdata),
        .i_raddr(ridx), .o_rdata(mk_rd)
    );
    pbwt_ram #(.WIDTH(HAP_W), .DEPTH(HLIM)) u_p0 (
        .i_clk(i_clk), .i_we(we0), .i_waddr(waddr), .i_wdata(HAP_W'(wdata_p)),
        .i_raddr(ridx), .o_rdata(p0_rd)
    );
    pbwt_ram #(.WIDTH(HAP_W), .DEPTH(HLIM)) u_p1 (
        .i_clk(i_clk), .i_we(we1), .i_waddr(waddr), .i_wdata(HAP_W'(wdata_p)),
        .i_raddr(ridx), .o_rdata(p1_rd)
    );
    pbwt_ram #(.WIDTH(LENGTH_BITS), .DEPTH(HLIM)) u_d0 (
        .i_clk(i_clk), .i_we(we0), .i_waddr(waddr), .i_wdata(wdata_d),
        .i_raddr(ridx), .o_rdata(d0_rd)
    );
    pbwt_ram #(.WIDTH(LENGTH_BITS), .DEPTH(HLIM)) u_d1 (
        .i_clk(i_clk), .i_we(we1), .i_waddr(waddr), .i_wdata(wdata_d),
        .i_raddr(ridx), .o_rdata(d1_rd)
    );

    a_tready_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> (r_state == ST_LOAD))
        else $error("input taken outside load");
    a_write_passb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (we0 || we1) |-> (r_state == ST_PASSB))
        else $error("array write outside partition pass");
    a_zeros_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PASSB) |-> (r_zeros <= r_h))
        else $error("zero count exceeds height");
    a_last_swap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_acc && r_o_last && !i_cfg_valid) |=> (r_state == ST_LOAD && !r_fresh))
        else $error("column end did not return to load");
endmodule
